// File: rtl/core/direct_mapped_frame_cache_macros.svh
// assertion macros for the frame cache
`ifndef DIRECT_MAPPED_FRAME_CACHE_MACROS_SVH
`define DIRECT_MAPPED_FRAME_CACHE_MACROS_SVH

`ifndef ASSERT_OFF
`define DMFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dmfc assertion failed");
`define DMFC_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dmfc assertion failed");
`else
`define DMFC_ASSERT(label, clk, rst_n, prop)
`define DMFC_ASSERT_NR(label, clk, prop)
`endif

`endif

// File: rtl/core/dmfc_pkg.sv
// types, constants and helpers shared by the frame cache
package dmfc_pkg;

    localparam int SLOTS       = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FRAME_BYTES = 8;
    localparam int ACT_W       = 2;
    localparam int ID_W        = 29;
    localparam int HASH_W      = 32;
    localparam int LEN_W       = 4;
    localparam int PAY_W       = 64;
    localparam int STAMP_W     = 64;
    localparam int CNT_W       = 32;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INVAL  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    frame_id;
        logic [HASH_W-1:0]  content_hash;
        logic [PAY_W-1:0]   payload;
        logic [LEN_W-1:0]   length;
        logic [STAMP_W-1:0] stamp;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [LEN_W-1:0]   found_length;
        logic [PAY_W-1:0]   found_payload;
        logic [STAMP_W-1:0] found_stamp;
        logic [CNT_W-1:0]   hits_total;
        logic [CNT_W-1:0]   misses_total;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]    tag;
        logic [HASH_W-1:0]  hash;
        logic [LEN_W-1:0]   length;
        logic [PAY_W-1:0]   payload;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // bytes below len are written, all of them when len is eight or more
    function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [PAY_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            mask[i*8 +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

endpackage

// File: rtl/core/dmfc_if.sv
// valid/ready channels for requests and responses
interface dmfc_req_if;
    import dmfc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dmfc_rsp_if;
    import dmfc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/dmfc_ram.sv
// generic single write, single read ram with registered read data
module dmfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/direct_mapped_frame_cache.sv
// direct-mapped cache of can frames: top level
// An accepted request reads its slot (frame_id modulo the slot count) from the slot ram.
// In the read state the tag and hash are checked; once the response register is free or
// being taken, a store writes the merged entry back and the response register is loaded.
// A new request is taken only after the read state is done, so requests do not overlap;
// this is set by the read-then-write of the single slot ram. Responses wait in a register,
// so a request is still taken while the previous response waits for its transfer.
// Valid bits live in flip-flops cleared by reset; there is no clearing pass.
`include "direct_mapped_frame_cache_macros.svh"

module direct_mapped_frame_cache (
    input logic       i_clk,
    input logic       i_rst_n,
    dmfc_req_if.sink  i_req,
    dmfc_rsp_if.source o_rsp
);
    import dmfc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic               r_state, n_state;
    t_req               r_req;
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [SLOTS-1:0]   r_paid, n_paid;
    logic [CNT_W-1:0]   r_hits, n_hits;
    logic [CNT_W-1:0]   r_misses, n_misses;
    t_rsp               r_rsp, n_rsp;
    logic               r_out_valid, n_out_valid;

    logic               w_accept;
    logic               w_done;
    logic               w_hit;
    logic [IDX_W-1:0]   w_idx_in;
    logic [IDX_W-1:0]   w_idx;
    logic [ENTRY_W-1:0] w_rd_raw;
    t_entry             w_entry;
    t_entry             w_new;
    logic [PAY_W-1:0]   w_old_pay;
    logic [PAY_W-1:0]   w_mask;
    logic               w_we;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_done      = (r_state == ST_READ) && (!r_out_valid || o_rsp.ready);

    assign w_idx_in = IDX_W'(i_req.data.frame_id % SLOTS);
    assign w_idx    = IDX_W'(r_req.frame_id % SLOTS);

    assign w_entry   = t_entry'(w_rd_raw);
    assign w_old_pay = r_paid[w_idx] ? w_entry.payload : '0;
    assign w_mask    = byte_mask(r_req.length);

    assign w_new.tag     = r_req.frame_id;
    assign w_new.hash    = r_req.content_hash;
    assign w_new.length  = r_req.length;
    assign w_new.payload = (w_old_pay & ~w_mask) | (r_req.payload & w_mask);
    assign w_new.stamp   = r_req.stamp;

    assign w_hit = (r_req.action == ACT_LOOKUP) && r_valid[w_idx]
                && (w_entry.tag == r_req.frame_id) && (w_entry.hash == r_req.content_hash);
    assign w_we  = w_done && (r_req.action == ACT_STORE);

    dmfc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_new),
        .i_re    (w_accept),
        .i_raddr (w_idx_in),
        .o_rdata (w_rd_raw)
    );

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_paid      = r_paid;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                    case (r_req.action)
                        ACT_LOOKUP: begin
                            if (w_hit) begin
                                n_hits = r_hits + 1'b1;
                            end else begin
                                n_misses = r_misses + 1'b1;
                            end
                        end
                        ACT_STORE: begin
                            n_valid[w_idx] = 1'b1;
                            n_paid[w_idx]  = 1'b1;
                        end
                        ACT_INVAL: begin
                            n_valid = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.hit           = w_hit;
                    n_rsp.found_length  = w_hit ? w_entry.length : '0;
                    n_rsp.found_payload = w_hit ? w_old_pay : '0;
                    n_rsp.found_stamp   = w_hit ? w_entry.stamp : '0;
                    n_rsp.hits_total    = n_hits;
                    n_rsp.misses_total  = n_misses;
                    n_out_valid         = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_paid      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_paid      <= n_paid;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.data;
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    `DMFC_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> (!o_rsp.valid && r_state == ST_IDLE))
    `DMFC_ASSERT(a_accept_reads, i_clk, i_rst_n, w_accept |=> (r_state == ST_READ))
    `DMFC_ASSERT(a_one_count, i_clk, i_rst_n,
        (r_hits != $past(r_hits)) |-> (r_misses == $past(r_misses)))
    `DMFC_ASSERT(a_miss_zero, i_clk, i_rst_n,
        (o_rsp.valid && !o_rsp.data.hit) |-> (o_rsp.data.found_length == '0
            && o_rsp.data.found_payload == '0 && o_rsp.data.found_stamp == '0))

endmodule

// File: dv/tb_direct_mapped_frame_cache.sv
// self-checking testbench for the direct-mapped frame cache: directed and random requests
module tb_direct_mapped_frame_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import dmfc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int N_RANDOM   = 700;
    localparam int MAX_KEYS   = 32;
    localparam int MAX_REPORT = 10;

    typedef struct {
        t_req req;
        bit   hold;
    } stim_item_t;

    logic i_clk;
    logic i_rst_n;

    dmfc_req_if req_if ();
    dmfc_rsp_if rsp_if ();

    direct_mapped_frame_cache u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the slot store
    logic               cache_valid   [SLOTS];
    logic [ID_W-1:0]    cache_tag     [SLOTS];
    logic [HASH_W-1:0]  cache_hash    [SLOTS];
    logic [LEN_W-1:0]   cache_length  [SLOTS];
    logic [PAY_W-1:0]   cache_payload [SLOTS];
    logic [STAMP_W-1:0] cache_stamp   [SLOTS];
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;

    stim_item_t stim_q [$];
    stim_item_t next_item;
    t_rsp       expected_rsp_q [$];
    t_rsp       rsp_got;
    t_rsp       rsp_want;

    logic [ID_W-1:0]   key_id   [$];
    logic [HASH_W-1:0] key_hash [$];

    int unsigned acc_cnt;
    int unsigned rcv_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatch_count;
    int          n_lookup;
    int          n_store;
    int          n_inval;
    int          n_spare;

    function automatic t_rsp predict_frame_cache(input t_req r);
        t_rsp             res;
        logic [IDX_W-1:0] slot;
        int               nbytes;
        res  = '0;
        slot = IDX_W'(r.frame_id % SLOTS);
        case (r.action)
            ACT_LOOKUP: begin
                n_lookup++;
                if (cache_valid[slot] && cache_tag[slot] == r.frame_id &&
                    cache_hash[slot] == r.content_hash) begin
                    res.hit           = 1'b1;
                    res.found_length  = cache_length[slot];
                    res.found_payload = cache_payload[slot];
                    res.found_stamp   = cache_stamp[slot];
                    hit_count         = hit_count + 1'b1;
                end else begin
                    miss_count = miss_count + 1'b1;
                end
            end
            ACT_STORE: begin
                n_store++;
                nbytes = (r.length > FRAME_BYTES) ? FRAME_BYTES : int'(r.length);
                for (int b = 0; b < nbytes; b++) begin
                    cache_payload[slot][b*8 +: 8] = r.payload[b*8 +: 8];
                end
                cache_tag[slot]    = r.frame_id;
                cache_hash[slot]   = r.content_hash;
                cache_length[slot] = r.length;
                cache_stamp[slot]  = r.stamp;
                cache_valid[slot]  = 1'b1;
            end
            ACT_INVAL: begin
                n_inval++;
                for (int s = 0; s < SLOTS; s++) begin
                    cache_valid[s] = 1'b0;
                end
            end
            default: begin
                n_spare++;
            end
        endcase
        res.hits_total   = hit_count;
        res.misses_total = miss_count;
        return res;
    endfunction

    function automatic t_req make_req(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                                      input logic [HASH_W-1:0] hash, input logic [PAY_W-1:0] pay,
                                      input logic [LEN_W-1:0] len, input logic [STAMP_W-1:0] stamp);
        t_req r;
        r.action       = act;
        r.frame_id     = id;
        r.content_hash = hash;
        r.payload      = pay;
        r.length       = len;
        r.stamp        = stamp;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_item(input t_req r, input bit hold);
        stim_item_t it;
        it.req  = r;
        it.hold = hold;
        stim_q.push_back(it);
    endtask

    task automatic remember_key(input logic [ID_W-1:0] id, input logic [HASH_W-1:0] hash);
        int k;
        if (key_id.size() < MAX_KEYS) begin
            key_id.push_back(id);
            key_hash.push_back(hash);
        end else begin
            k = $urandom_range(MAX_KEYS - 1);
            key_id[k]   = id;
            key_hash[k] = hash;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT) begin
                $display("result %0d: %s expected %h got %h", rcv_cnt, name, want, got);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsp_q.push_back(predict_frame_cache(req_if.data));
                acc_cnt <= acc_cnt + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    (!stim_q[0].hold || (!req_if.valid && acc_cnt == rcv_cnt))) begin
                    next_item = stim_q.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.data  <= next_item.req;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_got = rsp_if.data;
                if (expected_rsp_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT) begin
                        $display("result %0d: unexpected transfer, got %h", rcv_cnt, rsp_got);
                    end
                end else begin
                    rsp_want = expected_rsp_q.pop_front();
                    check_field("hit", 64'(rsp_want.hit), 64'(rsp_got.hit));
                    check_field("found_length", 64'(rsp_want.found_length),
                                64'(rsp_got.found_length));
                    check_field("found_payload", rsp_want.found_payload, rsp_got.found_payload);
                    check_field("found_stamp", rsp_want.found_stamp, rsp_got.found_stamp);
                    check_field("hits_total", 64'(rsp_want.hits_total), 64'(rsp_got.hits_total));
                    check_field("misses_total", 64'(rsp_want.misses_total),
                                64'(rsp_got.misses_total));
                end
                rcv_cnt <= rcv_cnt + 1;
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int                total;
        int                pick;
        int                k;
        logic [ID_W-1:0]   id;
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  len;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        rsp_if.ready   = 1'b0;
        acc_cnt        = 0;
        rcv_cnt        = 0;
        mismatch_count = 0;
        n_lookup       = 0;
        n_store        = 0;
        n_inval        = 0;
        n_spare        = 0;
        hit_count      = '0;
        miss_count     = '0;
        send_idle_pct  = 6;
        recv_idle_pct  = 81;
        for (int s = 0; s < SLOTS; s++) begin
            cache_valid[s]   = 1'b0;
            cache_payload[s] = '0;
        end

        // directed part
        push_item(make_req(ACT_LOOKUP, '0, '0, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_STORE, '0, '0, '1, 4'd8, '1), 1'b0);
        push_item(make_req(ACT_LOOKUP, '0, '0, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, '0, '1, '0, '0, '0), 1'b0);
        // same slot, other tag, partial payload write
        push_item(make_req(ACT_STORE, ID_W'(SLOTS), 32'h1234_5678, '0, 4'd3, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, '0, '0, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, ID_W'(SLOTS), 32'h1234_5678, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_STORE, '1, '1, 64'h0f1e_2d3c_4b5a_6978, 4'd15, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, '1, '1, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_STORE, '1, '1, '0, 4'd0, 64'd1), 1'b0);
        push_item(make_req(ACT_LOOKUP, '1, '1, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_SPARE, '1, '1, '0, 4'd8, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, '1, '1, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_STORE, ID_W'(5), 32'hdead_beef, 64'h0123_4567_89ab_cdef, 4'd9,
                           64'h8000_0000_0000_0000), 1'b0);
        push_item(make_req(ACT_LOOKUP, ID_W'(5), 32'hdead_beef, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_INVAL, '0, '0, '0, '0, '0), 1'b1);
        push_item(make_req(ACT_LOOKUP, ID_W'(5), 32'hdead_beef, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, '1, '1, '0, '0, '0), 1'b0);
        // contents survive invalidate, only byte 0 rewritten
        push_item(make_req(ACT_STORE, ID_W'(5), 32'hdead_beef, '0, 4'd1, 64'd7), 1'b0);
        push_item(make_req(ACT_LOOKUP, ID_W'(5), 32'hdead_beef, '0, '0, '0), 1'b0);
        push_item(make_req(ACT_LOOKUP, 29'h1fff_fff5, 32'hdead_beef, '0, '0, '0), 1'b0);

        // random part
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(99);
            k    = (key_id.size() != 0) ? $urandom_range(key_id.size() - 1) : 0;
            id   = ID_W'($urandom);
            hash = $urandom;
            len  = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(15))
                                            : LEN_W'($urandom_range(8));
            if (pick < 34) begin
                if (key_id.size() != 0 && $urandom_range(3) == 0) begin
                    id = {id[ID_W-1:IDX_W], key_id[k][IDX_W-1:0]};
                end else if (key_id.size() != 0 && $urandom_range(2) == 0) begin
                    id = key_id[k];
                end
                remember_key(id, hash);
                push_item(make_req(ACT_STORE, id, hash, rand64(), len, rand64()),
                          n % 150 == 149);
            end else if (pick < 92) begin
                pick = $urandom_range(99);
                if (key_id.size() != 0 && pick < 60) begin
                    id   = key_id[k];
                    hash = key_hash[k];
                end else if (key_id.size() != 0 && pick < 75) begin
                    id = key_id[k];
                end else if (key_id.size() != 0 && pick < 85) begin
                    id = {id[ID_W-1:IDX_W], key_id[k][IDX_W-1:0]};
                    hash = key_hash[k];
                end
                push_item(make_req(ACT_LOOKUP, id, hash, rand64(), len, rand64()),
                          n % 150 == 149);
            end else if (pick < 96) begin
                push_item(make_req(ACT_SPARE, id, hash, rand64(), len, rand64()), 1'b0);
            end else begin
                push_item(make_req(ACT_INVAL, id, hash, rand64(), len, rand64()), 1'b0);
            end
        end
        total = stim_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() > (2 * total) / 3) @(negedge i_clk);
        send_idle_pct = 81;
        recv_idle_pct = 6;
        while (stim_q.size() > total / 3) @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        while (stim_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (expected_rsp_q.size() != 0) begin
            mismatch_count += expected_rsp_q.size();
            $display("%0d expected results never arrived", expected_rsp_q.size());
        end
        $display("covered %0d requests: %0d lookups (%0d hits, %0d misses), %0d stores,",
                 acc_cnt, n_lookup, hit_count, miss_count, n_store);
        $display("%0d invalidates and %0d unused action codes; %0d mismatches",
                 n_inval, n_spare, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
